// File: src/grayscale_sobel_edge_defines.svh
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - assertion macros
// Shared assertion helpers. Each macro samples on clk_i and is disabled while
// rst_ni is low, so it can only be used in modules with those port names.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_SOBEL_EDGE_DEFINES_SVH
`define GRAYSCALE_SOBEL_EDGE_DEFINES_SVH

// Same-cycle implication.
`define GSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gse assertion failed");

// Next-cycle implication.
`define GSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gse assertion failed");

`endif

// File: src/gse_pkg.sv
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - package
// Shared constants and the stage record passed to the window unit.
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int MaxLineDefault = 2048;
  localparam int LineWidthReset = 640;
  localparam int LineWidthMin   = 3;
  localparam int CfgWidth       = 12;
  localparam int PixW           = 8;
  localparam int ProdW          = 24;

  // Luma weights in unsigned Q0.16; they sum to 65536.
  localparam logic [15:0] WeightBlue  = 16'd4732;
  localparam logic [15:0] WeightGreen = 16'd46871;
  localparam logic [15:0] WeightRed   = 16'd13933;

  localparam logic [PixW-1:0] MagMax = 8'd255;

  typedef struct packed {
    logic [PixW-1:0] gray;
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic            produce;
    logic            row_last;
  } s2_t;

endpackage

// File: src/gse_line_buf.sv
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - line buffer
// Single memory holding the two previous gray rows as {upper, middle} per
// column, with a registered read and a write-to-read bypass.
// ----------------------------------------------------------------------------
`include "grayscale_sobel_edge_defines.svh"

module gse_line_buf #(
  parameter int Depth = gse_pkg::MaxLineDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [2*gse_pkg::PixW-1:0] wr_data_i,
  output logic [2*gse_pkg::PixW-1:0] rd_data_o
);

  logic [2*gse_pkg::PixW-1:0] mem [Depth];
  logic [2*gse_pkg::PixW-1:0] rd_q;
  logic [2*gse_pkg::PixW-1:0] fwd_data_q;
  logic                       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // A read that collides with the write of the same edge sees the new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

  `GSE_ASSERT_NEXT(a_bypass_capture, rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i), fwd_q && (rd_data_o == $past(wr_data_i)))
  `GSE_ASSERT_NEXT(a_read_holds, !rd_en_i && !wr_en_i, $stable(rd_data_o))

endmodule

// File: src/gse_sobel_win.sv
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - window and magnitude
// Keeps the two older window columns, forms |Gx|+|Gy| with the incoming
// column and holds the result word in the output register.
// ----------------------------------------------------------------------------
`include "grayscale_sobel_edge_defines.svh"

module gse_sobel_win (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s2_valid_i,
  input  gse_pkg::s2_t             s2_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [gse_pkg::PixW-1:0] edge_magnitude_o,
  output logic                     row_last_o
);

  // Column 1 is the older, left one; column 2 becomes the left of the next window.
  logic [gse_pkg::PixW-1:0] c1_top_q, c1_mid_q, c1_bot_q;
  logic [gse_pkg::PixW-1:0] c2_top_q, c2_mid_q, c2_bot_q;
  logic                     out_valid_q;
  logic [gse_pkg::PixW-1:0] mag_q;
  logic                     last_q;

  logic                      shift;
  logic [9:0]                right_s, left_s, upper_s, lower_s;
  logic signed [10:0]        gx, gy;
  logic [9:0]                gx_abs, gy_abs;
  logic [10:0]               mag_sum;
  logic [gse_pkg::PixW-1:0]  mag_sat;

  assign take_o = !out_valid_q || !out_stall_i;
  assign shift  = s2_valid_i && take_o;

  always_comb begin
    right_s = 10'(s2_i.top) + {1'b0, s2_i.mid, 1'b0} + 10'(s2_i.gray);
    left_s  = 10'(c1_top_q) + {1'b0, c1_mid_q, 1'b0} + 10'(c1_bot_q);
    upper_s = 10'(c1_top_q) + {1'b0, c2_top_q, 1'b0} + 10'(s2_i.top);
    lower_s = 10'(c1_bot_q) + {1'b0, c2_bot_q, 1'b0} + 10'(s2_i.gray);
    gx      = $signed({1'b0, right_s}) - $signed({1'b0, left_s});
    gy      = $signed({1'b0, upper_s}) - $signed({1'b0, lower_s});
    gx_abs  = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs  = gy[10] ? 10'(-gy) : gy[9:0];
    mag_sum = 11'(gx_abs) + 11'(gy_abs);
    mag_sat = (mag_sum > 11'(gse_pkg::MagMax)) ? gse_pkg::MagMax : mag_sum[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_top_q    <= '0;
      c1_mid_q    <= '0;
      c1_bot_q    <= '0;
      c2_top_q    <= '0;
      c2_mid_q    <= '0;
      c2_bot_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (shift) begin
        c1_top_q <= c2_top_q;
        c1_mid_q <= c2_mid_q;
        c1_bot_q <= c2_bot_q;
        c2_top_q <= s2_i.top;
        c2_mid_q <= s2_i.mid;
        c2_bot_q <= s2_i.gray;
      end
      if (take_o) begin
        out_valid_q <= s2_valid_i && s2_i.produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      mag_q  <= mag_sat;
      last_q <= s2_i.row_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = mag_q;
  assign row_last_o       = last_q;

  `GSE_ASSERT_NEXT(a_no_result_no_word, s2_valid_i && take_o && !s2_i.produce, !out_valid_o)

endmodule

// File: src/grayscale_sobel_edge.sv
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - top level
// Converts BGR pixels to gray and emits the saturated L1 Sobel magnitude.
// ----------------------------------------------------------------------------
// Input words (blue, green, red, frame_start) arrive in raster order on the
// in_valid_i / in_stall_o channel; result words leave on out_valid_o /
// out_stall_i. A word moves on an edge where valid is high and stall is low.
// One input word is taken per clock while in_stall_o is low. A result
// passes both stages and the output register; pixels in the first two rows
// or columns of a frame give no result. The rate is set by the line memory,
// read once on acceptance, written once when the pixel leaves the first stage.
// cfg_wr_en_i / cfg_wr_data_i load the line width; write it only while idle.
// Widths below 3 act as 3 and widths above MAX_LINE act as MAX_LINE.
// Reset clears the position counters, the window and the pipeline, and sets
// the width to 640; line memory contents stay undefined until written.
// While the receiver stalls, the output register holds its word and the
// two internal stages keep filling, then in_stall_o rises.
// ----------------------------------------------------------------------------
`include "grayscale_sobel_edge_defines.svh"

module grayscale_sobel_edge #(
  parameter int MAX_LINE = gse_pkg::MaxLineDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wr_en_i,
  input  logic [gse_pkg::CfgWidth-1:0] cfg_wr_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gse_pkg::PixW-1:0]     blue_i,
  input  logic [gse_pkg::PixW-1:0]     green_i,
  input  logic [gse_pkg::PixW-1:0]     red_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gse_pkg::PixW-1:0]     edge_magnitude_o,
  output logic                         row_last_o
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int WW = CW + 1;
  localparam int LW = (WW > gse_pkg::CfgWidth) ? WW : gse_pkg::CfgWidth;
  localparam int ResetWidth = (gse_pkg::LineWidthReset > MAX_LINE) ?
                              MAX_LINE : gse_pkg::LineWidthReset;

  // Configuration: the clamped width is kept ready for the column compare.
  logic [WW-1:0] width_q;
  logic [LW-1:0] cfg_ext;
  logic [WW-1:0] width_d;

  always_comb begin
    cfg_ext = LW'(cfg_wr_data_i);
    if (cfg_ext < LW'(gse_pkg::LineWidthMin)) begin
      width_d = WW'(gse_pkg::LineWidthMin);
    end else if (cfg_ext > LW'(MAX_LINE)) begin
      width_d = WW'(MAX_LINE);
    end else begin
      width_d = cfg_ext[WW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WW'(ResetWidth);
    end else if (cfg_wr_en_i) begin
      width_q <= width_d;
    end
  end

  // Handshake and stage control.
  logic          in_acc;
  logic          s1_valid_q, s2_valid_q;
  logic          s1_ready, s2_ready, s1_adv, take;

  assign s2_ready   = !s2_valid_q || take;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // Raster position.
  logic [CW-1:0] col_q, col_d, col_eff;
  logic [1:0]    row_q, row_d, row_eff;
  logic [WW-1:0] col_inc;
  logic          wrap, produce, is_last;

  always_comb begin
    col_eff = frame_start_i ? '0 : col_q;
    row_eff = frame_start_i ? '0 : row_q;
    col_inc = {1'b0, col_eff} + WW'(1);
    wrap    = col_inc >= width_q;
    is_last = col_inc == width_q;
    produce = (row_eff == 2'd2) && (col_eff >= CW'(2));
    col_d   = wrap ? '0 : col_inc[CW-1:0];
    row_d   = (wrap && (row_eff != 2'd2)) ? row_eff + 2'd1 : row_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // First stage: weighted channels and line memory read.
  logic [CW-1:0]              s1_col_q;
  logic [gse_pkg::ProdW-1:0]  s1_pb_q, s1_pg_q, s1_pr_q;
  logic                       s1_produce_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q     <= col_eff;
      s1_pb_q      <= gse_pkg::ProdW'(gse_pkg::WeightBlue) * gse_pkg::ProdW'(blue_i);
      s1_pg_q      <= gse_pkg::ProdW'(gse_pkg::WeightGreen) * gse_pkg::ProdW'(green_i);
      s1_pr_q      <= gse_pkg::ProdW'(gse_pkg::WeightRed) * gse_pkg::ProdW'(red_i);
      s1_produce_q <= produce;
      s1_last_q    <= is_last;
    end
  end

  logic [gse_pkg::ProdW-1:0]   luma_sum;
  logic [gse_pkg::PixW-1:0]    gray;
  logic [2*gse_pkg::PixW-1:0]  line_rd;
  logic [gse_pkg::PixW-1:0]    top_px, mid_px;

  assign luma_sum = s1_pb_q + s1_pg_q + s1_pr_q;
  assign gray     = luma_sum[gse_pkg::ProdW-1 -: gse_pkg::PixW];
  assign top_px   = line_rd[2*gse_pkg::PixW-1 -: gse_pkg::PixW];
  assign mid_px   = line_rd[gse_pkg::PixW-1:0];

  gse_line_buf #(
    .Depth (MAX_LINE),
    .AddrW (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_eff),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid_px, gray}),
    .rd_data_o (line_rd)
  );

  // Second stage register feeding the window.
  gse_pkg::s2_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q.gray     <= gray;
      s2_q.top      <= top_px;
      s2_q.mid      <= mid_px;
      s2_q.produce  <= s1_produce_q;
      s2_q.row_last <= s1_last_q;
    end
  end

  gse_sobel_win u_sobel_win (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s2_valid_i       (s2_valid_q),
    .s2_i             (s2_q),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_magnitude_o (edge_magnitude_o),
    .row_last_o       (row_last_o)
  );

  `GSE_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s2_ready, s1_valid_q && $stable(s1_col_q))
  `GSE_ASSERT_NEXT(a_frame_restart, in_acc && frame_start_i, (s1_col_q == '0) && !s1_produce_q)
  `GSE_ASSERT_IMPL(a_row_saturates, 1'b1, row_q != 2'd3)

endmodule

// File: tb/sv/grayscale_sobel_edge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale Sobel edge - testbench
// Drives BGR pixel words through the block with random gaps and stalls on both
// channels. A local predictor of the gray conversion, line memories and 3x3
// window computes every edge word, and each received word is checked in order.
// ----------------------------------------------------------------------------
module grayscale_sobel_edge_test;

  localparam int MaxLine       = gse_pkg::MaxLineDefault;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 4000;
  localparam int RandomPixels  = 650;

  typedef enum int {
    ContentNoise,
    ContentSmooth,
    ContentBinary
  } content_e;

  typedef struct packed {
    logic [gse_pkg::PixW-1:0] magnitude;
    logic                     row_last;
  } edge_word_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_wr_en_i;
  logic [gse_pkg::CfgWidth-1:0] cfg_wr_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [gse_pkg::PixW-1:0]     blue_i;
  logic [gse_pkg::PixW-1:0]     green_i;
  logic [gse_pkg::PixW-1:0]     red_i;
  logic                         frame_start_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [gse_pkg::PixW-1:0]     edge_magnitude_o;
  logic                         row_last_o;

  // Predictor state.
  logic [gse_pkg::PixW-1:0]     older_row_mem [MaxLine];
  logic [gse_pkg::PixW-1:0]     prior_row_mem [MaxLine];
  logic [gse_pkg::PixW-1:0]     tap [9];
  int                           pix_col;
  int                           pix_row;
  logic [gse_pkg::CfgWidth-1:0] width_reg;
  edge_word_t                   expected_edges [$];

  int   error_count   = 0;
  int   words_checked = 0;
  int   pixels_sent   = 0;
  int   idle_cycles   = 0;
  int   hold_left     = 0;
  int   stall_left    = 0;
  logic no_gaps       = 1'b0;
  logic no_stalls     = 1'b0;

  grayscale_sobel_edge #(
    .MAX_LINE(MaxLine)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .blue_i           (blue_i),
    .green_i          (green_i),
    .red_i            (red_i),
    .frame_start_i    (frame_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_magnitude_o (edge_magnitude_o),
    .row_last_o       (row_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int active_width();
    if (width_reg < gse_pkg::LineWidthMin) return gse_pkg::LineWidthMin;
    if (width_reg > MaxLine) return MaxLine;
    return int'(width_reg);
  endfunction

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advances the local copy of the block by one pixel and queues the edge
  // word that the pixel produces, if any.
  function automatic void predict_edge_word(input logic [gse_pkg::PixW-1:0] b, g, r,
                                            input logic fs);
    logic [31:0]              luma_sum;
    logic [gse_pkg::PixW-1:0] gray, top, mid;
    int                       w, c, k, right_sum, left_sum, top_sum, bottom_sum, mag;
    edge_word_t               word;
    w = active_width();
    if (fs) begin
      pix_col = 0;
      pix_row = 0;
    end
    c = pix_col % MaxLine;
    luma_sum = 32'(gse_pkg::WeightBlue) * 32'(b) + 32'(gse_pkg::WeightGreen) * 32'(g) +
               32'(gse_pkg::WeightRed) * 32'(r);
    gray = luma_sum[23:16];
    top = older_row_mem[c];
    mid = prior_row_mem[c];
    older_row_mem[c] = mid;
    prior_row_mem[c] = gray;
    for (k = 0; k < 3; k++) begin
      tap[3 * k]     = tap[3 * k + 1];
      tap[3 * k + 1] = tap[3 * k + 2];
    end
    tap[2] = top;
    tap[5] = mid;
    tap[8] = gray;
    if (pix_row >= 2 && c >= 2) begin
      right_sum  = int'(tap[2]) + 2 * int'(tap[5]) + int'(tap[8]);
      left_sum   = int'(tap[0]) + 2 * int'(tap[3]) + int'(tap[6]);
      top_sum    = int'(tap[0]) + 2 * int'(tap[1]) + int'(tap[2]);
      bottom_sum = int'(tap[6]) + 2 * int'(tap[7]) + int'(tap[8]);
      mag = abs_diff(right_sum, left_sum) + abs_diff(top_sum, bottom_sum);
      if (mag > int'(gse_pkg::MagMax)) mag = int'(gse_pkg::MagMax);
      word.magnitude = 8'(mag);
      word.row_last  = (c == w - 1);
      expected_edges.push_back(word);
    end
    c++;
    if (c >= w) begin
      c = 0;
      if (pix_row < 2) pix_row++;
    end
    pix_col = c;
  endfunction

  // Mostly zero, sometimes a few cycles, now and then a long stretch.
  function automatic int pick_idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [gse_pkg::PixW-1:0] pick_channel(
      input content_e mode, input logic [gse_pkg::PixW-1:0] base);
    case (mode)
      ContentSmooth: return base + 8'($urandom_range(0, 20));
      ContentBinary: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at word %0d: got %0d, want %0d", what, words_checked, got,
             want);
    error_count++;
  endtask

  // Offers one pixel word and holds it until the block takes it. Valid is left
  // high; every caller moves to a falling edge before the next rising one.
  task automatic send_pixel(input logic [gse_pkg::PixW-1:0] b, g, r, input logic fs);
    int gap;
    gap = no_gaps ? 0 : pick_idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    blue_i        = b;
    green_i       = g;
    red_i         = r;
    frame_start_i = fs;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_edge_word(b, g, r, fs);
    pixels_sent++;
  endtask

  task automatic send_frame(input int rows, input int extra, input content_e mode,
                            input logic lead_fs, input int restart_odds);
    int                       count, p;
    logic [gse_pkg::PixW-1:0] base;
    logic                     fs;
    base  = 8'($urandom_range(0, 235));
    count = rows * active_width() + extra;
    for (p = 0; p < count; p++) begin
      if (p == 0) fs = lead_fs;
      else fs = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
      send_pixel(pick_channel(mode, base), pick_channel(mode, base),
                 pick_channel(mode, base), fs);
    end
  endtask

  // Pixels that give no word may still be in the pipeline once the queue is
  // empty, so a few more cycles pass before the block counts as idle.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_edges.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_line_width(input logic [gse_pkg::CfgWidth-1:0] value);
    drain_block();
    cfg_wr_en_i   = 1'b1;
    cfg_wr_data_i = value;
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
    width_reg   = value;
  endtask

  // At the reset width these pixels stay within the first row, so no word
  // may appear.
  task automatic test_reset_width();
    send_frame(0, 24, ContentSmooth, 1'b1, 0);
  endtask

  task automatic test_pixel_extremes();
    set_line_width(gse_pkg::CfgWidth'(gse_pkg::LineWidthMin));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    send_pixel(8'h81, 8'h80, 8'h7F, 1'b0);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    // A frame start in the middle of a row restarts the position counters.
    send_pixel(8'h0A, 8'h14, 8'h1E, 1'b0);
    send_frame(2, 3, ContentBinary, 1'b1, 0);
  endtask

  // Narrowing the line while the column already lies beyond the new width:
  // that pixel still gives a word, then the position wraps.
  task automatic test_midrow_narrow();
    set_line_width(12'd6);
    send_frame(2, 5, ContentNoise, 1'b1, 0);
    set_line_width(12'd4);
    send_frame(2, 1, ContentNoise, 1'b0, 0);
  endtask

  task automatic test_width_limits();
    set_line_width('0);
    send_frame(4, 0, ContentNoise, 1'b1, 0);
    set_line_width('1);
    no_gaps   = 1'b1;
    no_stalls = 1'b1;
    send_frame(0, 40, ContentSmooth, 1'b1, 0);
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
    set_line_width(12'd2);
    send_frame(3, 1, ContentSmooth, 1'b1, 0);
    set_line_width(12'd1);
    send_frame(3, 0, ContentNoise, 1'b1, 0);
  endtask

  task automatic test_backpressure();
    set_line_width(12'd8);
    no_gaps   = 1'b1;
    hold_left = 80;
    send_frame(25, 0, ContentNoise, 1'b1, 0);
    no_gaps = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_frame(4, 0, ContentSmooth, 1'b1, 0);
    drain_block();
    send_frame(4, 2, ContentSmooth, 1'b0, 0);
  endtask

  task automatic test_random_frames();
    int random_goal, roll, frames, f;
    random_goal = pixels_sent + RandomPixels;
    while (pixels_sent < random_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) set_line_width(gse_pkg::CfgWidth'($urandom_range(3, 12)));
      else if (roll < 93) set_line_width(gse_pkg::CfgWidth'($urandom_range(13, 80)));
      else set_line_width(gse_pkg::CfgWidth'($urandom_range(0, 2)));
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        no_gaps   = ($urandom_range(0, 4) == 0);
        no_stalls = no_gaps;
        // After a width change the first frame must restart the position.
        send_frame($urandom_range(3, 6), 0, content_e'($urandom_range(0, 2)),
                   (f == 0) || ($urandom_range(0, 3) != 0), 60);
      end
      no_gaps   = 1'b0;
      no_stalls = 1'b0;
    end
  endtask

  // Receiver stall: requested hold-off first, none under no_stalls, else random runs.
  initial begin
    out_stall_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (no_stalls) begin
        out_stall_i = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left  = pick_idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    edge_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("unexpected word", int'(edge_magnitude_o), -1);
      end else begin
        want = expected_edges.pop_front();
        if (edge_magnitude_o !== want.magnitude)
          report_mismatch("edge_magnitude", int'(edge_magnitude_o), int'(want.magnitude));
        if (row_last_o !== want.row_last)
          report_mismatch("row_last", int'(row_last_o), int'(want.row_last));
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[grayscale_sobel_edge] ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i    = 1'b0;
    blue_i        = '0;
    green_i       = '0;
    red_i         = '0;
    frame_start_i = 1'b0;
    for (i = 0; i < MaxLine; i++) begin
      older_row_mem[i] = '0;
      prior_row_mem[i] = '0;
    end
    for (i = 0; i < 9; i++) tap[i] = '0;
    pix_col   = 0;
    pix_row   = 0;
    width_reg = gse_pkg::CfgWidth'(gse_pkg::LineWidthReset);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_width();
    test_pixel_extremes();
    test_midrow_narrow();
    test_width_limits();
    test_backpressure();
    test_sender_pause();
    test_random_frames();
    drain_block();

    if (error_count == 0) begin
      $display("[grayscale_sobel_edge] OK");
    end else begin
      $display("[grayscale_sobel_edge] ERROR");
    end
    $finish;
  end

endmodule
